// ===== sv/dhpe_pkg.sv =====
// shared constants and helpers for the delta hex percent encoder
package dhpe_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned SlotW = 3;

  // ascii codes used by the encoder
  localparam logic [ByteW-1:0] PctChar   = 8'h25;
  localparam logic [ByteW-1:0] ZeroChar  = 8'h30;
  localparam logic [ByteW-1:0] NineChar  = 8'h39;
  localparam logic [ByteW-1:0] LowAChar  = 8'h61;
  localparam logic [ByteW-1:0] LowFChar  = 8'h66;

  // character slots within one encoded byte group
  localparam logic [SlotW-1:0] SlotPct0  = 3'd0;
  localparam logic [SlotW-1:0] SlotHi0   = 3'd1;
  localparam logic [SlotW-1:0] SlotLo0   = 3'd2;
  localparam logic [SlotW-1:0] SlotPct1  = 3'd3;
  localparam logic [SlotW-1:0] SlotHi1   = 3'd4;
  localparam logic [SlotW-1:0] SlotLo1   = 3'd5;

  // lower-case hex digit for one nibble
  function automatic logic [ByteW-1:0] hex_digit(input logic [3:0] nib);
    logic [ByteW-1:0] wide;
    wide = {4'h0, nib};
    if (nib < 4'd10) begin
      hex_digit = ZeroChar + wide;
    end else begin
      hex_digit = LowAChar + wide - 8'd10;
    end
  endfunction

endpackage

// ===== sv/delta_hex_percent_encoder_top.sv =====
// delta hex percent encoder: byte stream in, escaped delta hex text out
//
//   channel  | dir | tdata            | tlast
//   s_axis   | in  | [7:0] char_in    | last_in
//   m_axis   | out | [7:0] char_out   | last_out
//
// each input word gives three output words, a final word gives six;
// output runs at one word a cycle while m_tready is high; the character serialiser
// loads a new word only once the last character of the word before it is taken.
// one input register decouples s_tready from m_tready; it takes the next word
// while the current characters are still being sent
// rst is synchronous, active high, and clears the running sum and previous byte
module delta_hex_percent_encoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_in
  input  logic       s_tlast,   // last_in
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] char_out
  output logic       m_tlast    // last_out
);

  logic                               in_full;
  logic [dhpe_pkg::ByteW-1:0]         in_char;
  logic                               in_last;

  logic                               busy;
  logic [dhpe_pkg::SlotW-1:0]         slot;
  logic [dhpe_pkg::ByteW-1:0]         delta0;
  logic [dhpe_pkg::ByteW-1:0]         delta1;
  logic                               item_fin;

  logic [dhpe_pkg::ByteW-1:0]         byte_sum;
  logic [dhpe_pkg::ByteW-1:0]         previous_byte;
  logic [dhpe_pkg::ByteW-1:0]         sum_next;

  logic                               s_acc;
  logic                               m_acc;
  logic                               finish;
  logic                               load;
  logic [dhpe_pkg::SlotW-1:0]         end_slot;

  // handshakes
  assign s_tready = !in_full;
  assign s_acc    = s_tvalid && s_tready;
  assign m_tvalid = busy;
  assign m_acc    = m_tvalid && m_tready;
  assign end_slot = item_fin ? dhpe_pkg::SlotLo1 : dhpe_pkg::SlotLo0;
  assign finish   = m_acc && (slot == end_slot);
  assign load     = in_full && (!busy || finish);

  // running sum including the word being loaded
  assign sum_next = byte_sum + in_char;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full       <= 1'b0;
      busy          <= 1'b0;
      slot          <= dhpe_pkg::SlotPct0;
      byte_sum      <= '0;
      previous_byte <= '0;
    end else begin
      if (s_acc) begin
        in_full <= 1'b1;
      end else if (load) begin
        in_full <= 1'b0;
      end

      if (load) begin
        busy <= 1'b1;
        slot <= dhpe_pkg::SlotPct0;
      end else if (finish) begin
        busy <= 1'b0;
      end else if (m_acc) begin
        slot <= slot + 3'd1;
      end

      // message state, cleared after a final word
      if (load) begin
        if (in_last) begin
          byte_sum      <= '0;
          previous_byte <= '0;
        end else begin
          byte_sum      <= sum_next;
          previous_byte <= in_char;
        end
      end
    end
  end

  // input word register
  always_ff @(posedge clk) begin
    if (s_acc) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // deltas for the word being sent, the checksum delta is against the final byte
  always_ff @(posedge clk) begin
    if (load) begin
      delta0   <= in_char - previous_byte;
      delta1   <= sum_next - in_char;
      item_fin <= in_last;
    end
  end

  // character select
  always_comb begin
    m_tlast = 1'b0;
    unique case (slot)
      dhpe_pkg::SlotPct0: m_tdata = dhpe_pkg::PctChar;
      dhpe_pkg::SlotHi0:  m_tdata = dhpe_pkg::hex_digit(delta0[7:4]);
      dhpe_pkg::SlotLo0:  m_tdata = dhpe_pkg::hex_digit(delta0[3:0]);
      dhpe_pkg::SlotPct1: m_tdata = dhpe_pkg::PctChar;
      dhpe_pkg::SlotHi1:  m_tdata = dhpe_pkg::hex_digit(delta1[7:4]);
      dhpe_pkg::SlotLo1: begin
        m_tdata = dhpe_pkg::hex_digit(delta1[3:0]);
        m_tlast = 1'b1;
      end
      default:            m_tdata = dhpe_pkg::PctChar;
    endcase
  end

endmodule

// ===== sv/dhpe_checker.sv =====
// port checker for the delta hex percent encoder, with its bind
module dhpe_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // only percent signs and lower-case hex digits leave the block
  a_out_alphabet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == dhpe_pkg::PctChar)
      || (m_tdata >= dhpe_pkg::ZeroChar && m_tdata <= dhpe_pkg::NineChar)
      || (m_tdata >= dhpe_pkg::LowAChar && m_tdata <= dhpe_pkg::LowFChar))
    else $error("output word outside the encoded alphabet");

  // the closing word of a message is a hex digit, never the escape
  a_last_digit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata != dhpe_pkg::PctChar)
    else $error("last word is an escape");

  // a percent sign is always followed by a hex digit
  a_pct_then_digit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tdata == dhpe_pkg::PctChar
      |=> !m_tvalid || m_tdata != dhpe_pkg::PctChar)
    else $error("escape not followed by a digit");

  // nothing is offered straight after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind delta_hex_percent_encoder_top dhpe_checker u_dhpe_checker (.*);

// ===== bench/dhpe_checker.sv =====
// stream checker for the delta hex percent encoder: predicts and compares output words
`timescale 1ns / 1ps

module dhpe_scoreboard (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,
  input  logic       m_tlast,
  output int         errors,
  output int         pending,
  output int         bytes_in,
  output int         msgs_in,
  output int         chars_out
);

  typedef struct packed {
    logic [dhpe_pkg::ByteW-1:0] ch;
    logic                       lst;
  } enc_char_t;

  // expected characters, oldest first
  enc_char_t char_queue[$];

  // running state of the current message
  logic [dhpe_pkg::ByteW-1:0] msg_sum;
  logic [dhpe_pkg::ByteW-1:0] last_byte;

  // lower-case ascii hex for one nibble
  function automatic logic [dhpe_pkg::ByteW-1:0] nibble_ascii(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return dhpe_pkg::ZeroChar + {4'h0, nib};
    end
    return dhpe_pkg::LowAChar + ({4'h0, nib} - 8'd10);
  endfunction

  // queue '%', high digit, low digit of the mod-256 difference
  task automatic queue_escaped_delta(input logic [dhpe_pkg::ByteW-1:0] cur,
                                     input logic [dhpe_pkg::ByteW-1:0] prev,
                                     input logic fin);
    logic [dhpe_pkg::ByteW-1:0] delta;
    delta = cur - prev;
    char_queue.push_back('{ch: dhpe_pkg::PctChar, lst: 1'b0});
    char_queue.push_back('{ch: nibble_ascii(delta[7:4]), lst: 1'b0});
    char_queue.push_back('{ch: nibble_ascii(delta[3:0]), lst: fin});
  endtask

  // predict the characters for one accepted input byte
  task automatic encode_byte(input logic [dhpe_pkg::ByteW-1:0] b, input logic fin);
    queue_escaped_delta(b, last_byte, 1'b0);
    msg_sum   = msg_sum + b;
    last_byte = b;
    if (fin) begin
      queue_escaped_delta(msg_sum, last_byte, 1'b1);
      msg_sum   = '0;
      last_byte = '0;
      msgs_in++;
    end
  endtask

  task automatic report(input string what, input logic [8:0] got, input logic [8:0] want);
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  // watch both channels at every edge
  always @(posedge clk) begin
    enc_char_t want;
    if (rst) begin
      msg_sum   = '0;
      last_byte = '0;
      errors    = 0;
      bytes_in  = 0;
      msgs_in   = 0;
      chars_out = 0;
      char_queue.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        encode_byte(s_tdata, s_tlast);
        bytes_in++;
      end
      if (m_tvalid && m_tready) begin
        chars_out++;
        if (char_queue.size() == 0) begin
          report("unexpected output word", {m_tlast, m_tdata}, 9'h0);
        end else begin
          want = char_queue.pop_front();
          if (m_tdata !== want.ch) begin
            report("char_out", {1'b0, m_tdata}, {1'b0, want.ch});
          end
          if (m_tlast !== want.lst) begin
            report("last_out", {8'h0, m_tlast}, {8'h0, want.lst});
          end
        end
      end
    end
    pending = char_queue.size();
  end

endmodule

// ===== bench/testbench.sv =====
// top of the delta hex percent encoder bench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;

  localparam int RandItems = 160;
  localparam int LongHold  = 60;
  localparam int DrainWait = 30;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tlast;

  int errors;
  int pending;
  int bytes_in;
  int msgs_in;
  int chars_out;

  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_now;
  bit long_hold_done;

  logic [7:0] prev_sent;
  int         sent;

  delta_hex_percent_encoder_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  dhpe_scoreboard u_scoreboard (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .errors    (errors),
    .pending   (pending),
    .bytes_in  (bytes_in),
    .msgs_in   (msgs_in),
    .chars_out (chars_out)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #400000;
    $display("timeout with %0d characters still expected", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // offer one input word and hold it until taken, with an optional gap before it
  task automatic send_word(input logic [7:0] b, input logic fin);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    prev_sent = b;
    sent++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // random byte leaning towards extremes, tabs and repeats
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h09;
      3: return prev_sent;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // receiver: random stall bursts, and one long hold-off on request
  initial begin
    m_tready       = 1'b0;
    long_hold_done = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_now && !long_hold_done) begin
        m_tready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // stimulus
  initial begin
    int msg_len;
    int start_cnt;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tlast        = 1'b0;
    rst            = 1'b1;
    tx_idle_on     = 1'b1;
    rx_idle_on     = 1'b1;
    hold_now       = 1'b0;
    prev_sent      = '0;
    sent           = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one-byte messages at both extremes
    send_word(8'h00, 1'b1);
    send_word(8'hff, 1'b1);
    // deltas that wrap in both directions
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h7f, 1'b1);
    // fields joined by tab bytes
    send_word(8'h41, 1'b0);
    send_word(8'h09, 1'b0);
    send_word(8'h42, 1'b0);
    send_word(8'h09, 1'b1);
    // checksum wrapping past 256
    send_word(8'hff, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(8'hff, 1'b1);
    // alternating bit patterns
    send_word(8'ha5, 1'b0);
    send_word(8'h5a, 1'b1);

    // random messages; mostly short, a few longer
    start_cnt = sent;
    while (sent - start_cnt < RandItems) begin
      msg_len = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
      for (int i = 0; i < msg_len; i++) begin
        int idx;
        idx = sent - start_cnt;
        // long output hold-off with the sender going flat out
        if (idx == 60) begin
          hold_now = 1'b1;
        end
        tx_idle_on = (idx < 140) && !(idx >= 60 && idx < 85);
        rx_idle_on = (idx < 140);
        send_word(pick_byte(), i == msg_len - 1);
      end
    end
    s_tvalid <= 1'b0;

    // drain
    while (pending != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("sent %0d bytes in %0d messages, checked %0d characters", bytes_in, msgs_in,
             chars_out);
    $display("covered wrapping deltas, checksum overflow, one-byte messages %s",
             "and output backpressure");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
